// ===== sv/pcq_pkg.sv =====
// Package for the palette color quantizer: field widths, mode and command codes,
// item structs and the posterize function. No dependencies.
`default_nettype none

package pcq_pkg;

   localparam int CHAN_W      = 8;
   localparam int INDEX_W     = 6;
   localparam int COUNT_W     = 7;
   localparam int MODE_W      = 2;
   localparam int CSR_IDX_W   = 1;
   localparam int DIST_W      = 18;   // 3 * 255^2 fits
   localparam int SQ_W        = 2 * CHAN_W;
   localparam int INDEX_LIMIT = 64;
   localparam int POST_BIAS   = 42;
   localparam int POST_STEP   = 85;

   localparam logic [MODE_W-1:0] MODE_PASS      = 2'd0;
   localparam logic [MODE_W-1:0] MODE_POSTERIZE = 2'd1;
   localparam logic [MODE_W-1:0] MODE_PALETTE   = 2'd2;

   localparam logic CMD_PIXEL = 1'b0;
   localparam logic CMD_WRITE = 1'b1;

   localparam logic [CSR_IDX_W-1:0] CSR_COLOR_MODE    = 1'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_PALETTE_COUNT = 1'd1;

   localparam logic [COUNT_W-1:0] COUNT_RESET = 7'd16;

   typedef struct packed {
      logic [CHAN_W-1:0] blue;
      logic [CHAN_W-1:0] green;
      logic [CHAN_W-1:0] red;
   } color_type;

   typedef struct packed {
      logic              command;
      logic [CHAN_W-1:0] blue_in;
      logic [CHAN_W-1:0] green_in;
      logic [CHAN_W-1:0] red_in;
      logic [INDEX_W-1:0] entry_index;
   } req_type;

   typedef struct packed {
      logic [CHAN_W-1:0] blue_out;
      logic [CHAN_W-1:0] green_out;
      logic [CHAN_W-1:0] red_out;
      logic [INDEX_W-1:0] chosen_index;
   } rsp_type;

   // travels with each palette entry through the distance pipeline
   typedef struct packed {
      logic [INDEX_W-1:0] idx;
      color_type          color;
      logic               last;
   } tag_type;

   // (c + 42) / 85 * 85 as three threshold compares
   function automatic logic [CHAN_W-1:0] posterize(input logic [CHAN_W-1:0] c);
      localparam int T1 = POST_STEP - POST_BIAS;
      localparam int T2 = 2 * POST_STEP - POST_BIAS;
      localparam int T3 = 3 * POST_STEP - POST_BIAS;
      logic [CHAN_W-1:0] level;
      if (32'(c) < T1) begin
         level = '0;
      end else if (32'(c) < T2) begin
         level = CHAN_W'(POST_STEP);
      end else if (32'(c) < T3) begin
         level = CHAN_W'(2 * POST_STEP);
      end else begin
         level = CHAN_W'(3 * POST_STEP);
      end
      return level;
   endfunction

endpackage

`default_nettype wire

// ===== sv/pcq_dist.sv =====
// Three-stage squared-distance pipeline: per-channel difference, square, sum.
// Depends on pcq_pkg.
`default_nettype none

module pcq_dist
   import pcq_pkg::*;
(
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              in_valid,
   input  wire color_type         pixel,
   input  wire color_type         entry,
   input  wire tag_type           in_tag,
   output logic                   out_valid,
   output logic [DIST_W-1:0]      out_dist,
   output tag_type                out_tag
);

   function automatic logic [CHAN_W-1:0] abs_diff(input logic [CHAN_W-1:0] a,
                                                   input logic [CHAN_W-1:0] b);
      return (a > b) ? (a - b) : (b - a);
   endfunction

   logic [2:0]        valid_ff;
   logic [2:0]        valid_in;
   logic [CHAN_W-1:0] diff_ff [3];
   logic [SQ_W-1:0]   sq_ff [3];
   logic [DIST_W-1:0] sum_ff;
   tag_type           tag_ff [3];

   assign valid_in = {valid_ff[1:0], in_valid};

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      diff_ff[0] <= abs_diff(pixel.blue, entry.blue);
      diff_ff[1] <= abs_diff(pixel.green, entry.green);
      diff_ff[2] <= abs_diff(pixel.red, entry.red);
      tag_ff[0]  <= in_tag;

      for (int k = 0; k < 3; k++) begin
         sq_ff[k] <= SQ_W'(diff_ff[k]) * SQ_W'(diff_ff[k]);
      end
      tag_ff[1] <= tag_ff[0];

      sum_ff    <= DIST_W'(sq_ff[0]) + DIST_W'(sq_ff[1]) + DIST_W'(sq_ff[2]);
      tag_ff[2] <= tag_ff[1];
   end

   assign out_valid = valid_ff[2];
   assign out_dist  = sum_ff;
   assign out_tag   = tag_ff[2];

endmodule

`default_nettype wire

// ===== sv/palette_color_quantizer.sv =====
// Palette color quantizer: pass-through, four-level posterize or nearest palette
// color per pixel item; palette write items load the palette RAM. A palette write
// gives no result. In palette mode the searched count is palette_count clamped to
// 1..min(PALETTE_DEPTH, 64): the palette RAM's one read port supplies one entry
// per cycle into a five-stage read, distance and compare pipeline. The block
// holds req_stall high while a pixel is in progress. Palette entries come up
// undefined after reset and must be written before they are searched.
// Depends on pcq_pkg and pcq_dist.
`default_nettype none

module palette_color_quantizer
   import pcq_pkg::*;
#(
   parameter int PALETTE_DEPTH = 64
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_valid,
   output logic                       req_stall,
   input  wire req_type               req_data,
   output logic                       rsp_valid,
   input  wire logic                  rsp_stall,
   output rsp_type                    rsp_data,
   input  wire logic                  csr_valid,
   output logic                       csr_ready,
   input  wire logic [CSR_IDX_W-1:0]  csr_index,
   input  wire logic [COUNT_W-1:0]    csr_wdata
);

   localparam int ADDR_W = (PALETTE_DEPTH > 1) ? $clog2(PALETTE_DEPTH) : 1;
   localparam int SEARCH_LIMIT = (PALETTE_DEPTH < INDEX_LIMIT) ? PALETTE_DEPTH : INDEX_LIMIT;

   typedef enum logic [2:0] {
      ST_IDLE   = 3'b001,
      ST_SEARCH = 3'b010,
      ST_DONE   = 3'b100
   } state_type;

   state_type           state_ff, state_in;
   logic [MODE_W-1:0]   color_mode_ff;
   logic [COUNT_W-1:0]  palette_count_ff;
   color_type           pix_ff;
   logic [INDEX_W-1:0]  issue_ff, issue_in;
   logic                issuing_ff, issuing_in;
   logic                rd_valid_ff;
   logic [INDEX_W-1:0]  rd_idx_ff;
   logic                rd_last_ff;
   color_type           rd_color_ff;
   logic [DIST_W-1:0]   best_dist_ff;
   logic [INDEX_W-1:0]  best_idx_ff;
   color_type           best_color_ff;
   logic                rsp_valid_ff, rsp_valid_in;
   rsp_type             rsp_data_ff, rsp_data_in;

   color_type           palette_mem [PALETTE_DEPTH];

   logic                req_fire;
   logic                pixel_fire;
   logic                wr_en;
   logic [ADDR_W-1:0]   wr_addr;
   logic [ADDR_W-1:0]   rd_addr;
   logic [COUNT_W-1:0]  search_n;
   logic                last_issue;
   logic                issue_now;
   logic                rsp_load;
   logic                best_take;
   color_type           req_color;
   tag_type             dist_tag_in;
   logic                dist_valid;
   logic [DIST_W-1:0]   dist_value;
   tag_type             dist_tag;

   assign req_stall  = (state_ff != ST_IDLE);
   assign req_fire   = req_valid && !req_stall;
   assign pixel_fire = req_fire && (req_data.command == CMD_PIXEL);
   assign req_color  = '{blue: req_data.blue_in, green: req_data.green_in,
                         red: req_data.red_in};

   // writes past the RAM depth are dropped
   assign wr_en   = req_fire && (req_data.command == CMD_WRITE) &&
                    (32'(req_data.entry_index) < 32'(PALETTE_DEPTH));
   assign wr_addr = ADDR_W'(req_data.entry_index);
   assign rd_addr = ADDR_W'(issue_ff);

   always_comb begin
      if (palette_count_ff == '0) begin
         search_n = COUNT_W'(1);
      end else if (32'(palette_count_ff) > SEARCH_LIMIT) begin
         search_n = COUNT_W'(SEARCH_LIMIT);
      end else begin
         search_n = palette_count_ff;
      end
   end

   assign issue_now  = (state_ff == ST_SEARCH) && issuing_ff;
   assign last_issue = ({1'b0, issue_ff} == (search_n - COUNT_W'(1)));

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         palette_mem[wr_addr] <= req_color;
      end
      rd_color_ff <= palette_mem[rd_addr];
   end

   assign dist_tag_in = '{idx: rd_idx_ff, color: rd_color_ff, last: rd_last_ff};

   pcq_dist u_dist (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (rd_valid_ff),
      .pixel     (pix_ff),
      .entry     (rd_color_ff),
      .in_tag    (dist_tag_in),
      .out_valid (dist_valid),
      .out_dist  (dist_value),
      .out_tag   (dist_tag)
   );

   // strict less-than in index order keeps the lowest index on a tie
   assign best_take = dist_valid && (dist_value < best_dist_ff);

   assign rsp_load = (state_ff == ST_DONE) && (!rsp_valid_ff || !rsp_stall);

   always_comb begin
      state_in   = state_ff;
      issue_in   = issue_ff;
      issuing_in = issuing_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (pixel_fire) begin
               issue_in = '0;
               if (color_mode_ff == MODE_PALETTE) begin
                  state_in   = ST_SEARCH;
                  issuing_in = 1'b1;
               end else begin
                  state_in = ST_DONE;
               end
            end
         end
         ST_SEARCH: begin
            if (issue_now) begin
               issue_in = issue_ff + INDEX_W'(1);
               if (last_issue) begin
                  issuing_in = 1'b0;
               end
            end
            if (dist_valid && dist_tag.last) begin
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            if (rsp_load) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      priority if (color_mode_ff == MODE_PALETTE) begin
         rsp_data_in = '{blue_out: best_color_ff.blue, green_out: best_color_ff.green,
                         red_out: best_color_ff.red, chosen_index: best_idx_ff};
      end else if (color_mode_ff == MODE_POSTERIZE) begin
         rsp_data_in = '{blue_out: posterize(pix_ff.blue),
                         green_out: posterize(pix_ff.green),
                         red_out: posterize(pix_ff.red), chosen_index: '0};
      end else begin
         rsp_data_in = '{blue_out: pix_ff.blue, green_out: pix_ff.green,
                         red_out: pix_ff.red, chosen_index: '0};
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (rsp_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff         <= ST_IDLE;
         color_mode_ff    <= MODE_PASS;
         palette_count_ff <= COUNT_RESET;
         issuing_ff       <= 1'b0;
         rd_valid_ff      <= 1'b0;
         rsp_valid_ff     <= 1'b0;
      end else begin
         state_ff     <= state_in;
         issuing_ff   <= issuing_in;
         rd_valid_ff  <= issue_now;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_valid && csr_ready) begin
            unique case (csr_index)
               CSR_COLOR_MODE:    color_mode_ff    <= csr_wdata[MODE_W-1:0];
               CSR_PALETTE_COUNT: palette_count_ff <= csr_wdata;
               default: ;
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      issue_ff   <= issue_in;
      rd_idx_ff  <= issue_ff;
      rd_last_ff <= last_issue;
      if (pixel_fire) begin
         pix_ff       <= req_color;
         best_dist_ff <= '1;
      end else if (best_take) begin
         best_dist_ff  <= dist_value;
         best_idx_ff   <= dist_tag.idx;
         best_color_ff <= dist_tag.color;
      end
      if (rsp_load) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // issue pointer stays below the search limit
   assert property (@(posedge clock) disable iff (reset)
      issue_now |-> (32'(issue_ff) < SEARCH_LIMIT))
      else $error("palette read beyond search limit");

   // distance results only arrive during a search
   assert property (@(posedge clock) disable iff (reset)
      dist_valid |-> (state_ff == ST_SEARCH))
      else $error("distance result outside search");

   // a search ends only on the last entry's distance
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SEARCH && state_in == ST_DONE) |-> (dist_valid && dist_tag.last))
      else $error("search ended early");

   // a new result is always loaded from the done state
   assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == ST_DONE))
      else $error("result without finished pixel");

   // no palette entry is fetched once the search pipeline is draining
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SEARCH && !issuing_ff) |=> !rd_valid_ff)
      else $error("fetch after last entry");

endmodule

`default_nettype wire

// ===== dv/tb_top.sv =====
// Testbench for palette_color_quantizer: directed and random pixel and palette-write
// items, with results checked against an in-bench color predictor.
// Depends on pcq_pkg and the palette_color_quantizer RTL.
module tb_top;
   import pcq_pkg::*;

   localparam int DEPTH         = 64;
   localparam int CYCLE_LIMIT   = 1000000;
   localparam int SETTLE_CYCLES = 80;    // longest palette search plus margin
   localparam int LONG_HOLD     = 400;
   localparam int ITEM_BUDGET   = 1250;
   localparam logic [MODE_W-1:0] MODE_UNUSED = 2'd3;

   logic                 clock     = 1'b0;
   logic                 reset     = 1'b1;
   logic                 req_valid = 1'b0;
   logic                 req_stall;
   req_type              req_data  = '0;
   logic                 rsp_valid;
   logic                 rsp_stall = 1'b0;
   rsp_type              rsp_data;
   logic                 csr_valid = 1'b0;
   logic                 csr_ready;
   logic [CSR_IDX_W-1:0] csr_index = '0;
   logic [COUNT_W-1:0]   csr_wdata = '0;

   // predictor state
   color_type         palette_shadow [DEPTH];
   logic [MODE_W-1:0] mode_shadow  = MODE_PASS;
   logic [COUNT_W-1:0] count_shadow = COUNT_RESET;
   rsp_type           expected_colors [$];

   // stimulus state
   req_type   pending_items [$];
   color_type entry_plan [DEPTH];
   bit        entry_loaded [DEPTH];
   bit        calm = 1'b0;

   int error_count  = 0;
   int results_seen = 0;
   int send_gap     = 0;
   int stall_left   = 0;
   int hold_pick    = 0;
   int cycle_count  = 0;

   palette_color_quantizer dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // ---------------------------------------------------------------- predictor

   function automatic int searched_entries(input logic [COUNT_W-1:0] count);
      int n;
      n = int'(count);
      if (n == 0) n = 1;
      if (n > DEPTH) n = DEPTH;
      return n;
   endfunction

   function automatic int channel_gap(input int a, input int b);
      return (a - b) * (a - b);
   endfunction

   task automatic apply_request(input req_type item);
      rsp_type res;
      int      best;
      int      best_dist;
      int      gap_sum;
      if (item.command == CMD_WRITE) begin
         palette_shadow[item.entry_index] = {item.blue_in, item.green_in, item.red_in};
      end else begin
         res = '0;
         res.blue_out  = item.blue_in;
         res.green_out = item.green_in;
         res.red_out   = item.red_in;
         if (mode_shadow == MODE_POSTERIZE) begin
            res.blue_out  = CHAN_W'((int'(item.blue_in) + POST_BIAS) / POST_STEP * POST_STEP);
            res.green_out = CHAN_W'((int'(item.green_in) + POST_BIAS) / POST_STEP * POST_STEP);
            res.red_out   = CHAN_W'((int'(item.red_in) + POST_BIAS) / POST_STEP * POST_STEP);
         end else if (mode_shadow == MODE_PALETTE) begin
            best = 0;
            best_dist = 1 << 30;
            for (int i = 0; i < searched_entries(count_shadow); i++) begin
               gap_sum = channel_gap(int'(item.blue_in), int'(palette_shadow[i].blue))
                       + channel_gap(int'(item.green_in), int'(palette_shadow[i].green))
                       + channel_gap(int'(item.red_in), int'(palette_shadow[i].red));
               // strict compare keeps the lowest index on a tie
               if (gap_sum < best_dist) begin
                  best_dist = gap_sum;
                  best = i;
               end
            end
            res.blue_out     = palette_shadow[best].blue;
            res.green_out    = palette_shadow[best].green;
            res.red_out      = palette_shadow[best].red;
            res.chosen_index = INDEX_W'(best);
         end
         expected_colors.push_back(res);
      end
   endtask

   task automatic check_field(input string field, input logic [31:0] want,
                              input logic [31:0] got);
      if (got !== want) begin
         error_count++;
         $display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, want, got);
      end
   endtask

   task automatic check_result(input rsp_type got);
      rsp_type want;
      if (expected_colors.size() == 0) begin
         error_count++;
         $display("%0t: unexpected result, expected none, actual %h", $time, got);
      end else begin
         want = expected_colors.pop_front();
         check_field("blue_out", 32'(want.blue_out), 32'(got.blue_out));
         check_field("green_out", 32'(want.green_out), 32'(got.green_out));
         check_field("red_out", 32'(want.red_out), 32'(got.red_out));
         check_field("chosen_index", 32'(want.chosen_index), 32'(got.chosen_index));
      end
      results_seen++;
   endtask

   // mostly back-to-back, some short gaps, a few long ones
   function automatic int draw_idle();
      int r;
      r = $urandom_range(0, 99);
      if (calm || r < 65) return 0;
      if (r < 93) return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   // ---------------------------------------------------------------- driver

   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
         send_gap  <= 0;
      end else begin
         if (req_valid && !req_stall) begin
            apply_request(req_data);
         end
         if (!req_valid || !req_stall) begin
            if (send_gap > 0) begin
               req_valid <= 1'b0;
               send_gap  <= send_gap - 1;
            end else if (pending_items.size() > 0) begin
               req_data  <= pending_items.pop_front();
               req_valid <= 1'b1;
               send_gap  <= draw_idle();
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // ---------------------------------------------------------------- monitor

   always @(posedge clock) begin
      if (reset) begin
         rsp_stall  <= 1'b0;
         stall_left <= 0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            check_result(rsp_data);
         end
         // long hold-off so the block backs up into its input
         if (rsp_valid && !rsp_stall && (results_seen == 300 || results_seen == 900)) begin
            rsp_stall  <= 1'b1;
            stall_left <= LONG_HOLD;
         end else if (stall_left > 0) begin
            rsp_stall  <= 1'b1;
            stall_left <= stall_left - 1;
         end else begin
            hold_pick = draw_idle();
            rsp_stall  <= (hold_pick != 0);
            stall_left <= (hold_pick > 0) ? hold_pick - 1 : 0;
         end
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("== FAIL ==");
         $finish;
      end
   end

   // ---------------------------------------------------------------- stimulus

   function automatic logic [CHAN_W-1:0] pick_channel();
      int r;
      r = $urandom_range(0, 9);
      if (r == 0) return '0;
      if (r == 1) return '1;
      return CHAN_W'($urandom_range(0, 255));
   endfunction

   function automatic color_type random_color();
      color_type c;
      c.blue  = pick_channel();
      c.green = pick_channel();
      c.red   = pick_channel();
      return c;
   endfunction

   function automatic color_type near_color(input color_type c);
      color_type shifted;
      int        v;
      for (int k = 0; k < 3; k++) begin
         v = int'(c[CHAN_W*k +: CHAN_W]) - 6 + int'($urandom_range(0, 12));
         if (v < 0) v = 0;
         if (v > 255) v = 255;
         shifted[CHAN_W*k +: CHAN_W] = CHAN_W'(v);
      end
      return shifted;
   endfunction

   function automatic void queue_pixel(input color_type c);
      req_type item;
      item.command     = CMD_PIXEL;
      item.blue_in     = c.blue;
      item.green_in    = c.green;
      item.red_in      = c.red;
      item.entry_index = INDEX_W'($urandom_range(0, DEPTH - 1));
      pending_items.push_back(item);
   endfunction

   function automatic void queue_entry(input int slot, input color_type c);
      req_type item;
      item.command     = CMD_WRITE;
      item.blue_in     = c.blue;
      item.green_in    = c.green;
      item.red_in      = c.red;
      item.entry_index = INDEX_W'(slot);
      pending_items.push_back(item);
      entry_plan[slot]   = c;
      entry_loaded[slot] = 1'b1;
   endfunction

   task automatic set_register(input logic [CSR_IDX_W-1:0] which, input int value);
      @(posedge clock);
      csr_valid <= 1'b1;
      csr_index <= which;
      csr_wdata <= COUNT_W'(value);
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      if (which == CSR_COLOR_MODE) begin
         mode_shadow = MODE_W'(value);
      end else begin
         count_shadow = COUNT_W'(value);
      end
      @(negedge clock);
   endtask

   // all queued items sent and answered, then let any palette write finish
   task automatic wait_idle();
      do @(negedge clock);
      while (pending_items.size() != 0 || req_valid || expected_colors.size() != 0);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   initial begin
      int                quota;
      int                phase;
      int                items_left;
      int                r;
      int                slot;
      int                n;
      int                count_value;
      logic [MODE_W-1:0] mode_pick;
      color_type         a;
      color_type         b;
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // pass-through at reset settings, then load a few entries
      queue_pixel('{8'h00, 8'h00, 8'h00});
      queue_pixel('{8'hff, 8'hff, 8'hff});
      queue_pixel('{8'ha5, 8'h5a, 8'h3c});
      queue_entry(0, '{8'd0, 8'd0, 8'd0});
      queue_entry(1, '{8'd2, 8'd0, 8'd0});
      queue_entry(2, '{8'd255, 8'd255, 8'd255});
      queue_entry(3, '{8'd0, 8'd0, 8'd0});        // duplicate of entry 0
      queue_entry(63, '{8'd12, 8'd34, 8'd56});
      wait_idle();

      // posterize around each level threshold; upper data bits ignored
      set_register(CSR_COLOR_MODE, int'({5'b10101, MODE_POSTERIZE}));
      queue_pixel('{8'd42, 8'd43, 8'd127});
      queue_pixel('{8'd128, 8'd212, 8'd213});
      queue_pixel('{8'd0, 8'd255, 8'd84});
      queue_entry(4, '{8'd9, 8'd9, 8'd9});
      wait_idle();

      // palette: equidistant tie, exact duplicate, far corner, nearest non-zero
      set_register(CSR_COLOR_MODE, int'(MODE_PALETTE));
      set_register(CSR_PALETTE_COUNT, 4);
      queue_pixel('{8'd1, 8'd0, 8'd0});
      queue_pixel('{8'd0, 8'd0, 8'd0});
      queue_pixel('{8'd250, 8'd250, 8'd250});
      queue_pixel('{8'd3, 8'd1, 8'd0});
      wait_idle();

      // zero count searches entry 0 alone
      set_register(CSR_PALETTE_COUNT, 0);
      queue_pixel('{8'hff, 8'hff, 8'hff});
      wait_idle();

      set_register(CSR_COLOR_MODE, int'(MODE_UNUSED));
      queue_pixel('{8'd17, 8'd200, 8'd99});
      wait_idle();

      // random phases, each with its own settings
      quota = ITEM_BUDGET;
      phase = 0;
      while (quota > 0) begin
         if (phase < 2) begin
            mode_pick = MODE_PALETTE;
         end else begin
            r = $urandom_range(0, 9);
            mode_pick = (r < 5) ? MODE_PALETTE : (r < 7) ? MODE_POSTERIZE :
                        (r < 9) ? MODE_PASS : MODE_UNUSED;
         end
         r = $urandom_range(0, 99);
         if (phase == 0) count_value = 127;
         else if (phase == 1) count_value = 1;
         else if (r < 8) count_value = 0;
         else if (r < 16) count_value = 1;
         else if (r < 26) count_value = 64;
         else if (r < 34) count_value = 127;
         else if (r < 44) count_value = $urandom_range(65, 126);
         else count_value = $urandom_range(2, 63);
         set_register(CSR_COLOR_MODE,
                      (int'($urandom_range(0, 31)) << MODE_W) | int'(mode_pick));
         set_register(CSR_PALETTE_COUNT, count_value);
         calm = ($urandom_range(0, 3) == 0);

         // every searched entry gets written before any pixel reaches it
         n = searched_entries(COUNT_W'(count_value));
         for (slot = 0; slot < n; slot++) begin
            if (!entry_loaded[slot]) queue_entry(slot, random_color());
         end

         items_left = $urandom_range(60, 180);
         if (items_left > quota) items_left = quota;
         quota -= items_left;
         repeat (items_left) begin
            r = $urandom_range(0, 99);
            if (r < 4) begin
               // copy of a searched entry makes exact ties likely
               queue_entry($urandom_range(0, DEPTH - 1), entry_plan[$urandom_range(0, n - 1)]);
            end else if (r < 12) begin
               queue_entry($urandom_range(0, DEPTH - 1), random_color());
            end else if (r < 40) begin
               queue_pixel(near_color(entry_plan[$urandom_range(0, n - 1)]));
            end else if (r < 50) begin
               // halfway between two entries sits on or near a tie
               a = entry_plan[$urandom_range(0, n - 1)];
               b = entry_plan[$urandom_range(0, n - 1)];
               a.blue  = CHAN_W'((int'(a.blue) + int'(b.blue)) / 2);
               a.green = CHAN_W'((int'(a.green) + int'(b.green)) / 2);
               a.red   = CHAN_W'((int'(a.red) + int'(b.red)) / 2);
               queue_pixel(a);
            end else begin
               queue_pixel(random_color());
            end
         end
         wait_idle();
         phase++;
      end

      if (error_count == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

endmodule
